// File: rtl/msec_pkg.sv
// package for the mips subset execute core: opcodes, status codes, queue entry type
// no dependencies
`default_nettype none
package msec_pkg;
	localparam logic [31:0] RESET_PC   = 32'hBFC00000;
	localparam int          SR_ISO_BIT = 16;
	localparam int          QUEUE_DEPTH = 2;

	localparam logic [5:0] OPC_SPECIAL = 6'h00;
	localparam logic [5:0] OPC_J       = 6'h02;
	localparam logic [5:0] OPC_BNE     = 6'h05;
	localparam logic [5:0] OPC_ADDI    = 6'h08;
	localparam logic [5:0] OPC_ADDIU   = 6'h09;
	localparam logic [5:0] OPC_ORI     = 6'h0D;
	localparam logic [5:0] OPC_LUI     = 6'h0F;
	localparam logic [5:0] OPC_COP0    = 6'h10;
	localparam logic [5:0] OPC_LW      = 6'h23;
	localparam logic [5:0] OPC_SW      = 6'h2B;
	localparam logic [5:0] FN_SLL      = 6'h00;
	localparam logic [5:0] FN_OR       = 6'h25;
	localparam logic [4:0] CP0_SR      = 5'd12;

	localparam logic [1:0] MEM_NONE  = 2'd0;
	localparam logic [1:0] MEM_READ  = 2'd1;
	localparam logic [1:0] MEM_WRITE = 2'd2;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_BAD_FN  = 3'd1;
	localparam logic [2:0] ST_BAD_OPC = 3'd2;
	localparam logic [2:0] ST_BAD_CP0 = 3'd3;
	localparam logic [2:0] ST_ISOLATE = 3'd4;

	// one classified item passed from the front to the back
	typedef struct packed {
		logic        is_data;
		logic [31:0] word;
		logic [31:0] load_data;
	} item_t;
endpackage
`default_nettype wire

// File: rtl/msec_front.sv
// front part: accepts items and queues them for the back part
// depends on msec_pkg
`default_nettype none
module msec_front #(
	parameter int DEPTH = msec_pkg::QUEUE_DEPTH
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 valid,
	output logic                stall,
	input  wire                 req_type,
	input  wire  [31:0]         instr_word,
	input  wire  [31:0]         load_data,
	output logic                q_valid,
	input  wire                 q_pop,
	output msec_pkg::item_t     q_item
);
	import msec_pkg::*;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	item_t          mem_q [DEPTH];
	logic [AW-1:0]  wp_q, rp_q;
	logic [AW:0]    cnt_q;
	logic           push;

	assign stall   = (cnt_q == (AW+1)'(DEPTH));
	assign push    = valid && !stall;
	assign q_valid = (cnt_q != '0);
	assign q_item  = mem_q[rp_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= '{is_data: req_type, word: instr_word, load_data: load_data};
		end
	end

	// pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (q_pop) rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(q_pop);
		end
	end
endmodule
`default_nettype wire

// File: rtl/msec_back.sv
// back part: executes queued items and registers one result per item
// depends on msec_pkg
`default_nettype none
module msec_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 q_valid,
	output logic                q_pop,
	input  msec_pkg::item_t     q_item,
	output logic                out_valid,
	input  wire                 out_stall,
	output logic [31:0]         fetch_addr,
	output logic [1:0]          mem_op,
	output logic [31:0]         mem_addr,
	output logic [31:0]         store_data,
	output logic [2:0]          status
);
	import msec_pkg::*;

	logic [31:0] pc_q, held_q, sr_q, pval_q;
	logic [4:0]  pidx_q;
	logic [31:0] rf_q [32];

	logic [31:0] w, a, b, simm, pc4, sum, wval, npc, nsr, maddr, sdata;
	logic [5:0]  opc, fn;
	logic [4:0]  rs, rt, rd, sh, widx, npidx;
	logic        wen;
	logic [1:0]  op;
	logic [2:0]  st;

	assign q_pop = q_valid && (!out_valid || !out_stall);

	assign w    = held_q;
	assign opc  = w[31:26];
	assign rs   = w[25:21];
	assign rt   = w[20:16];
	assign rd   = w[15:11];
	assign sh   = w[10:6];
	assign fn   = w[5:0];
	assign a    = rf_q[rs];
	assign b    = rf_q[rt];
	assign simm = {{16{w[15]}}, w[15:0]};
	assign pc4  = pc_q + 32'd4;
	assign sum  = a + simm;

	// decode and execute the held instruction
	always_comb begin
		wen = 1'b0; widx = rt; wval = '0; npc = pc4; nsr = sr_q;
		op = MEM_NONE; maddr = '0; sdata = '0; st = ST_OK; npidx = '0;
		unique case (opc)
			OPC_LUI: begin wen = 1'b1; wval = {w[15:0], 16'h0}; end
			OPC_ORI: begin wen = 1'b1; wval = a | {16'h0, w[15:0]}; end
			OPC_ADDI, OPC_ADDIU: begin wen = 1'b1; wval = sum; end
			OPC_SPECIAL: begin
				widx = rd;
				if (fn == FN_SLL) begin wen = 1'b1; wval = b << sh; end
				else if (fn == FN_OR) begin wen = 1'b1; wval = a | b; end
				else st = ST_BAD_FN;
			end
			OPC_J: npc = {pc4[31:28], w[25:0], 2'b00};
			OPC_BNE: if (a != b) npc = pc4 + {simm[29:0], 2'b00} - 32'd4;
			OPC_SW: begin
				if (sr_q[SR_ISO_BIT]) st = ST_ISOLATE;
				else begin op = MEM_WRITE; maddr = sum; sdata = b; end
			end
			OPC_LW: begin
				if (sr_q[SR_ISO_BIT]) st = ST_ISOLATE;
				else begin op = MEM_READ; maddr = sum; npidx = rt; end
			end
			OPC_COP0: begin
				case (rd)
					5'd3, 5'd5, 5'd6, 5'd7, 5'd9, 5'd11, 5'd13:
						if (b != '0) st = ST_BAD_CP0;
					CP0_SR: nsr = b;
					default: st = ST_BAD_CP0;
				endcase
			end
			default: st = ST_BAD_OPC;
		endcase
	end

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= RESET_PC; held_q <= '0; sr_q <= '0; pval_q <= '0; pidx_q <= '0;
			for (int i = 0; i < 32; i++) rf_q[i] <= '0;
		end else if (q_pop) begin
			if (q_item.is_data) begin
				pval_q <= q_item.load_data;
			end else begin
				held_q <= q_item.word;
				pc_q   <= npc;
				sr_q   <= nsr;
				pidx_q <= npidx;
				pval_q <= '0;
				for (int i = 1; i < 32; i++) begin
					if (wen && widx == 5'(i)) rf_q[i] <= wval;
					else if (pidx_q == 5'(i)) rf_q[i] <= pval_q;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (q_pop) out_valid <= 1'b1;
		else if (!out_stall) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			if (q_item.is_data) begin
				fetch_addr <= pc_q; mem_op <= MEM_NONE; mem_addr <= '0;
				store_data <= '0; status <= ST_OK;
			end else begin
				fetch_addr <= npc; mem_op <= op; mem_addr <= maddr;
				store_data <= sdata; status <= st;
			end
		end
	end
endmodule
`default_nettype wire

// File: rtl/mips_subset_execute_core.sv
// top level of the mips subset execute core: front queue plus execute back end
// depends on msec_pkg, msec_front, msec_back
// an accepted item waits in the front queue; the back end then registers its result
// throughput: one item per cycle while the output is not stalled, set by the back end execute
// the two-entry queue lets input and output stall independently
// reset: pc to 0xBFC00000, registers, held word, status register and pending load cleared
`default_nettype none
module mips_subset_execute_core #(
	parameter int QUEUE_DEPTH = msec_pkg::QUEUE_DEPTH
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire         req_type,
	input  wire  [31:0] instr_word,
	input  wire  [31:0] load_data,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [31:0] fetch_addr,
	output logic [1:0]  mem_op,
	output logic [31:0] mem_addr,
	output logic [31:0] store_data,
	output logic [2:0]  status
);
	import msec_pkg::*;

	logic  q_valid, q_pop;
	item_t q_item;

	msec_front #(.DEPTH(QUEUE_DEPTH)) u_front (
		.clk, .arst_n, .valid(in_valid), .stall(in_stall),
		.req_type, .instr_word, .load_data,
		.q_valid, .q_pop, .q_item
	);

	msec_back u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_item,
		.out_valid, .out_stall,
		.fetch_addr, .mem_op, .mem_addr, .store_data, .status
	);
endmodule
`default_nettype wire
